FILE: design/bsa_pkg.sv
// Package for the buddy split allocator: constants, payload structs and
// the size-class helper. No dependencies.
package bsa_pkg;

    localparam int MaxLog2      = 16;
    localparam int MinLog2      = 5;
    localparam int MaxSegments  = 16;
    localparam int ClassCount   = MaxLog2 - MinLog2;
    localparam int BlkW         = ClassCount;
    localparam int SegW         = 4;
    localparam int LinkDepth    = MaxSegments * (1 << ClassCount);
    localparam int LinkAw       = $clog2(LinkDepth);
    localparam int ClsW         = $clog2(ClassCount + 1);
    localparam int NsegW        = $clog2(MaxSegments + 1);

    localparam logic FuncAlloc = 1'b0;
    localparam logic FuncFree  = 1'b1;

    localparam logic StatusOk    = 1'b0;
    localparam logic StatusNoSeg = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] request_size;
        logic [3:0]  free_segment;
        logic [15:0] free_offset;
        logic [31:0] free_size;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [3:0]  block_segment;
        logic [15:0] block_offset;
        logic [31:0] block_size;
    } t_out_word;

    // list node: segment and block index
    typedef struct packed {
        logic            valid;
        logic [SegW-1:0] seg;
        logic [BlkW-1:0] blk;
    } t_node;

    // ceil(log2 size) - MinLog2, saturated to ClassCount; sizes below min -> 0
    function automatic logic [ClsW-1:0] size_class(input logic [31:0] size);
        logic [32:0] v;
        int          n;
        v = {size, 1'b0} - 33'd1;
        n = 0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) n = i;
        end
        if (size < 32'(1 << MinLog2)) return '0;
        if (n - MinLog2 >= ClassCount) return ClsW'(ClassCount);
        return ClsW'(n - MinLog2);
    endfunction

endpackage

FILE: design/bsa_link_ram.sv
// Link memory of the free lists: one write and one registered read port.
// Depends on bsa_pkg.
module bsa_link_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [bsa_pkg::LinkAw-1:0] i_waddr,
    input  bsa_pkg::t_node        i_wdata,
    input  logic [bsa_pkg::LinkAw-1:0] i_raddr,
    output bsa_pkg::t_node        o_rdata
);
    import bsa_pkg::*;

    t_node r_mem [LinkDepth];
    t_node r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/buddy_split_allocator.sv
// Buddy split allocator: one word in, one result word out. An allocate served
// from a free list climbs from the request class to the first class with a
// free block, pops it (S_POP, S_POPW), then splits one level per step down
// to the request class, pushing each upper buddy; an allocate that finds no
// free block opens a fresh segment and splits it from the top class. An
// oversize allocate and a free go from class decode straight to output. The
// sequencer climbs class levels one per cycle in the head registers. The
// block is not ready while a word is in progress; a finished result waits in
// the output register while the next word is worked into a holding register.
// No clearing pass after reset. Depends on bsa_pkg and bsa_link_ram.
module buddy_split_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bsa_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output bsa_pkg::t_out_word o_data
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLASS, S_SCAN, S_POP, S_POPW, S_SPLIT, S_OUT
    } t_state;

    t_state          r_state;
    t_in_word        r_in;
    logic [ClsW-1:0] r_k, r_c;
    logic [SegW-1:0] r_seg;
    logic [BlkW-1:0] r_blk;
    t_node           r_heads [ClassCount];
    logic [NsegW-1:0] r_next_seg;
    logic [31:0]     r_seg_sizes [MaxSegments];
    t_out_word       r_res;
    t_out_word       r_out;
    logic            r_out_valid;

    // link memory port signals
    logic            w_we;
    logic [LinkAw-1:0] w_waddr, w_raddr;
    t_node           w_wdata, w_rdata;
    t_node           w_head_c;
    logic [ClsW-1:0] w_cm1;
    logic [BlkW-1:0] w_buddy;

    function automatic logic [LinkAw-1:0] laddr(input logic [SegW-1:0] s,
                                                input logic [BlkW-1:0] b);
        return LinkAw'({s, b});
    endfunction

    assign w_head_c = r_heads[r_c[$clog2(ClassCount)-1:0]];
    assign w_cm1    = r_c - ClsW'(1);
    assign w_buddy  = r_blk + (BlkW'(1) << w_cm1);

    bsa_link_ram u_links (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // link write: free push or split push
    always_comb begin
        w_we    = 1'b0;
        w_waddr = laddr(r_seg, r_blk);
        w_wdata = '0;
        w_raddr = laddr(w_head_c.seg, w_head_c.blk);
        if (r_state == S_CLASS && r_in.func == FuncFree && r_k < ClsW'(ClassCount)) begin
            w_we    = 1'b1;
            w_waddr = laddr(r_in.free_segment, r_in.free_offset[MinLog2 +: BlkW]);
            w_wdata = r_heads[r_k[$clog2(ClassCount)-1:0]];
        end else if (r_state == S_SPLIT && r_c > r_k) begin
            w_we    = 1'b1;
            w_waddr = laddr(r_seg, w_buddy);
            w_wdata = r_heads[w_cm1[$clog2(ClassCount)-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next_seg  <= NsegW'(1);
            for (int i = 0; i < ClassCount; i++) r_heads[i] <= '0;
            for (int i = 0; i < MaxSegments; i++) r_seg_sizes[i] <= '0;
        end else begin
            // output register: load from the holding register, or drain
            if (r_state == S_OUT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in    <= i_data;
                        r_k     <= size_class(i_data.func == FuncFree ?
                                              i_data.free_size : i_data.request_size);
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_c <= r_k;
                    if (r_in.func == FuncFree) begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                        if (r_k < ClsW'(ClassCount)) begin
                            r_heads[r_k[$clog2(ClassCount)-1:0]] <= '{1'b1,
                                r_in.free_segment, r_in.free_offset[MinLog2 +: BlkW]};
                        end else if (NsegW'(r_in.free_segment) < NsegW'(MaxSegments)) begin
                            r_seg_sizes[r_in.free_segment] <= '0;
                        end
                    end else if (r_k >= ClsW'(ClassCount)) begin
                        r_state <= S_OUT;
                        if (r_next_seg >= NsegW'(MaxSegments)) begin
                            r_res <= '{StatusNoSeg, SegW'(0), 16'd0, 32'd0};
                        end else begin
                            r_res <= '{StatusOk, SegW'(r_next_seg), 16'd0,
                                       r_in.request_size};
                            r_seg_sizes[SegW'(r_next_seg)] <= r_in.request_size;
                            r_next_seg <= r_next_seg + NsegW'(1);
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // climb one class a cycle
                    if (r_c == ClsW'(ClassCount)) begin
                        if (r_next_seg >= NsegW'(MaxSegments)) begin
                            r_res   <= '{StatusNoSeg, SegW'(0), 16'd0, 32'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_seg <= SegW'(r_next_seg);
                            r_blk <= '0;
                            r_seg_sizes[SegW'(r_next_seg)] <= 32'(1) << MaxLog2;
                            r_next_seg <= r_next_seg + NsegW'(1);
                            r_state <= S_SPLIT;
                        end
                    end else if (w_head_c.valid) begin
                        r_seg   <= w_head_c.seg;
                        r_blk   <= w_head_c.blk;
                        r_state <= S_POP;
                    end else begin
                        r_c <= r_c + ClsW'(1);
                    end
                end
                S_POP: r_state <= S_POPW;
                S_POPW: begin
                    r_heads[r_c[$clog2(ClassCount)-1:0]] <= w_rdata;
                    r_state <= S_SPLIT;
                end
                S_SPLIT: begin
                    // push upper buddy of each level down to k
                    if (r_c > r_k) begin
                        r_heads[w_cm1[$clog2(ClassCount)-1:0]] <= '{1'b1, r_seg, w_buddy};
                        r_c <= w_cm1;
                    end else begin
                        r_res <= '{StatusOk, r_seg, 16'({r_blk, MinLog2'(0)}),
                                   32'(1) << (r_k + ClsW'(MinLog2))};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_seg <= NsegW'(MaxSegments)) else $error("segment count overrun");
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPLIT |-> r_c >= r_k) else $error("split below class");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accepted while busy");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> w_head_c.valid) else $error("pop of empty list");
endmodule
